// ===== hw/rtl/box_blur_rgb_window_macros.svh =====
// ----------------------------------------------------------------------------
// box_blur_rgb_window_macros.svh
// Assertion macros shared by the blur checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_RGB_WINDOW_MACROS_SVH
`define BOX_BLUR_RGB_WINDOW_MACROS_SVH

// checked also while reset is asserted
`define BBRW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

// ignored while reset is asserted
`define BBRW_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bbrw_pkg.sv =====
// ----------------------------------------------------------------------------
// bbrw_pkg
// Types, constants and helpers of the RGB box blur.
// ----------------------------------------------------------------------------
package bbrw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RADIUS     = 3;

    localparam int RING    = 2 * RADIUS + 1;
    localparam int LINE_W  = (MAX_WIDTH > 2 * RADIUS) ? MAX_WIDTH : RING;
    localparam int DEPTH   = RING * LINE_W;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SLOT_W  = (RING > 1) ? $clog2(RING) : 1;
    localparam int COL_W   = $clog2(LINE_W);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int W_W     = $clog2(LINE_W + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int D_W     = $clog2(RADIUS * LINE_W + RADIUS + 2);
    localparam int DIM_W   = 11;
    localparam int POS_W   = 10;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int WIN     = RING * RING;
    localparam int CNT_W   = $clog2(WIN + 1);
    localparam int SUM_W   = $clog2(WIN * 255 + 1);
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] CFG_W_RST = DIM_W'(320);
    localparam logic [DIM_W-1:0] CFG_H_RST = DIM_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_DIV,
        B_HOLD
    } t_bstate;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel_color;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] blurred_color;
        logic [POS_W-1:0] out_column;
        logic [POS_W-1:0] out_row;
        logic             frame_done;
    } t_out_beat;

    typedef struct packed {
        logic [ROW_W-1:0]  er;
        logic [COL_W-1:0]  ec;
        logic [ROW_W-1:0]  r0;
        logic [ROW_W-1:0]  r1;
        logic [COL_W-1:0]  c0;
        logic [COL_W-1:0]  c1;
        logic [SLOT_W-1:0] slot0;
        logic              last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue;

    typedef struct packed {
        logic scan_busy;
        logic pop;
    } t_back_status;

    function automatic logic [W_W-1:0] clamp_w(input logic [DIM_W-1:0] v);
        if (int'(v) < RING) begin
            return W_W'(RING);
        end else if (int'(v) > LINE_W) begin
            return W_W'(LINE_W);
        end
        return W_W'(v);
    endfunction

    function automatic logic [H_W-1:0] clamp_h(input logic [DIM_W-1:0] v);
        logic [H_W-1:0] t;
        t = (int'(v) < RING) ? H_W'(RING) : H_W'(v);
        if (int'(v) < RING && RING > MAX_HEIGHT) begin
            t = H_W'(MAX_HEIGHT);
        end else if (int'(v) > MAX_HEIGHT) begin
            t = H_W'(MAX_HEIGHT);
        end
        return t;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(input logic [SLOT_W-1:0] s,
                                                     input logic [COL_W-1:0] c);
        return ADDR_W'(s) * ADDR_W'(LINE_W) + ADDR_W'(c);
    endfunction

endpackage

// ===== hw/rtl/bbrw_ram.sv =====
// ----------------------------------------------------------------------------
// bbrw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbrw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bbrw_front.sv =====
// ----------------------------------------------------------------------------
// bbrw_front
// Accepts beats, writes pixels to the line store and queues window jobs.
// ----------------------------------------------------------------------------
module bbrw_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  bbrw_pkg::t_in_beat              i_in_data,
    output logic                            o_in_stall,
    input  logic                            i_cfg_we,
    input  logic [bbrw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbrw_pkg::DIM_W-1:0]      i_cfg_data,
    input  bbrw_pkg::t_back_status          i_back,
    output bbrw_pkg::t_queue                o_queue,
    output logic                            o_wr_en,
    output logic [bbrw_pkg::ADDR_W-1:0]     o_wr_addr,
    output logic [bbrw_pkg::PIX_W-1:0]      o_wr_data
);

    logic [bbrw_pkg::DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [bbrw_pkg::W_W-1:0]    r_act_w;
    logic [bbrw_pkg::H_W-1:0]    r_act_h;
    logic [bbrw_pkg::COL_W-1:0]  r_in_col, r_em_col;
    logic [bbrw_pkg::ROW_W-1:0]  r_in_row, r_em_row;
    logic [bbrw_pkg::SLOT_W-1:0] r_in_slot, r_em_slot;
    logic                        r_done;
    logic [bbrw_pkg::D_W-1:0]    r_diff;
    bbrw_pkg::t_queue            r_q;

    logic                        accept, is_pix, is_fl, latch, emit_now;
    logic [bbrw_pkg::W_W-1:0]    eff_w;
    logic [bbrw_pkg::H_W-1:0]    eff_h;
    logic [bbrw_pkg::D_W-1:0]    diff_p, thr;
    logic                        in_col_wrap, in_row_wrap, em_col_wrap;
    bbrw_pkg::t_job              job;

    assign o_in_stall = r_q.valid || i_back.scan_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_pix = accept && (i_in_data.command == bbrw_pkg::CMD_PIXEL) && !r_done;
    assign is_fl  = accept && (i_in_data.command == bbrw_pkg::CMD_FLUSH) && r_done;
    assign latch  = is_pix && (r_in_row == '0) && (r_in_col == '0);
    assign eff_w  = latch ? bbrw_pkg::clamp_w(r_cfg_w) : r_act_w;
    assign eff_h  = latch ? bbrw_pkg::clamp_h(r_cfg_h) : r_act_h;

    assign diff_p = is_pix ? r_diff + bbrw_pkg::D_W'(1) : r_diff;
    assign thr    = bbrw_pkg::D_W'(eff_w) * bbrw_pkg::D_W'(bbrw_pkg::RADIUS)
                  + bbrw_pkg::D_W'(bbrw_pkg::RADIUS);
    assign emit_now = is_fl || (is_pix && (diff_p > thr));

    assign in_col_wrap = (bbrw_pkg::W_W'(r_in_col) + bbrw_pkg::W_W'(1)) >= eff_w;
    assign in_row_wrap = (bbrw_pkg::H_W'(r_in_row) + bbrw_pkg::H_W'(1)) >= eff_h;
    assign em_col_wrap = (bbrw_pkg::W_W'(r_em_col) + bbrw_pkg::W_W'(1)) >= eff_w;

    always_comb begin
        job.er = r_em_row;
        job.ec = r_em_col;
        job.r0 = (r_em_row > bbrw_pkg::ROW_W'(bbrw_pkg::RADIUS))
               ? r_em_row - bbrw_pkg::ROW_W'(bbrw_pkg::RADIUS) : '0;
        job.r1 = ((bbrw_pkg::H_W + 1)'(r_em_row) + (bbrw_pkg::H_W + 1)'(bbrw_pkg::RADIUS)
                  < (bbrw_pkg::H_W + 1)'(eff_h))
               ? bbrw_pkg::ROW_W'(r_em_row + bbrw_pkg::ROW_W'(bbrw_pkg::RADIUS))
               : bbrw_pkg::ROW_W'(eff_h - bbrw_pkg::H_W'(1));
        job.c0 = (r_em_col > bbrw_pkg::COL_W'(bbrw_pkg::RADIUS))
               ? r_em_col - bbrw_pkg::COL_W'(bbrw_pkg::RADIUS) : '0;
        job.c1 = ((bbrw_pkg::W_W + 1)'(r_em_col) + (bbrw_pkg::W_W + 1)'(bbrw_pkg::RADIUS)
                  < (bbrw_pkg::W_W + 1)'(eff_w))
               ? bbrw_pkg::COL_W'(r_em_col + bbrw_pkg::COL_W'(bbrw_pkg::RADIUS))
               : bbrw_pkg::COL_W'(eff_w - bbrw_pkg::W_W'(1));
        if (r_em_row > bbrw_pkg::ROW_W'(bbrw_pkg::RADIUS)) begin
            job.slot0 = (r_em_slot >= bbrw_pkg::SLOT_W'(bbrw_pkg::RADIUS))
                      ? r_em_slot - bbrw_pkg::SLOT_W'(bbrw_pkg::RADIUS)
                      : r_em_slot + bbrw_pkg::SLOT_W'(bbrw_pkg::RING - bbrw_pkg::RADIUS);
        end else begin
            job.slot0 = '0;
        end
        job.last = (bbrw_pkg::H_W'(r_em_row) == eff_h - bbrw_pkg::H_W'(1))
                && (bbrw_pkg::W_W'(r_em_col) == eff_w - bbrw_pkg::W_W'(1));
    end

    assign o_wr_en   = is_pix;
    assign o_wr_addr = bbrw_pkg::line_addr(r_in_slot, r_in_col);
    assign o_wr_data = i_in_data.pixel_color;
    assign o_queue   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= bbrw_pkg::CFG_W_RST;
            r_cfg_h   <= bbrw_pkg::CFG_H_RST;
            r_act_w   <= bbrw_pkg::clamp_w(bbrw_pkg::CFG_W_RST);
            r_act_h   <= bbrw_pkg::clamp_h(bbrw_pkg::CFG_H_RST);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
            r_em_col  <= '0;
            r_em_row  <= '0;
            r_em_slot <= '0;
            r_done    <= 1'b0;
            r_diff    <= '0;
            r_q.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bbrw_pkg::CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                    bbrw_pkg::CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (latch) begin
                r_act_w <= eff_w;
                r_act_h <= eff_h;
            end
            if (i_back.pop) begin
                r_q.valid <= 1'b0;
            end
            r_diff <= diff_p;
            if (is_pix) begin
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    if (in_row_wrap) begin
                        r_in_row  <= '0;
                        r_in_slot <= '0;
                        r_done    <= 1'b1;
                    end else begin
                        r_in_row  <= r_in_row + bbrw_pkg::ROW_W'(1);
                        r_in_slot <= (r_in_slot == bbrw_pkg::SLOT_W'(bbrw_pkg::RING - 1))
                                   ? '0 : r_in_slot + bbrw_pkg::SLOT_W'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + bbrw_pkg::COL_W'(1);
                end
            end
            if (emit_now) begin
                r_q.valid <= 1'b1;
                r_q.job   <= job;
                r_diff    <= diff_p - bbrw_pkg::D_W'(1);
                if (job.last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_in_slot <= '0;
                    r_em_col  <= '0;
                    r_em_row  <= '0;
                    r_em_slot <= '0;
                    r_done    <= 1'b0;
                    r_diff    <= '0;
                end else if (em_col_wrap) begin
                    r_em_col  <= '0;
                    r_em_row  <= r_em_row + bbrw_pkg::ROW_W'(1);
                    r_em_slot <= (r_em_slot == bbrw_pkg::SLOT_W'(bbrw_pkg::RING - 1))
                               ? '0 : r_em_slot + bbrw_pkg::SLOT_W'(1);
                end else begin
                    r_em_col <= r_em_col + bbrw_pkg::COL_W'(1);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/bbrw_back.sv =====
// ----------------------------------------------------------------------------
// bbrw_back
// Sums one window from the line store, divides and presents the result.
// ----------------------------------------------------------------------------
module bbrw_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbrw_pkg::t_queue            i_queue,
    output bbrw_pkg::t_back_status      o_status,
    output logic                        o_rd_en,
    output logic [bbrw_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [bbrw_pkg::PIX_W-1:0]  i_rd_data,
    output logic                        o_out_valid,
    output bbrw_pkg::t_out_beat         o_out_data,
    input  logic                        i_out_stall
);

    bbrw_pkg::t_bstate           r_state, n_state;
    bbrw_pkg::t_job              r_job;
    logic [bbrw_pkg::ROW_W-1:0]  r_row;
    logic [bbrw_pkg::COL_W-1:0]  r_col;
    logic [bbrw_pkg::SLOT_W-1:0] r_slot;
    logic                        r_rd_vld;
    logic [bbrw_pkg::SUM_W-1:0]  r_sum [3];
    logic [bbrw_pkg::CNT_W-1:0]  r_rem [3];
    logic [bbrw_pkg::CNT_W-1:0]  r_cnt;
    logic [bbrw_pkg::STEP_W-1:0] r_step;
    logic                        r_out_valid;
    bbrw_pkg::t_out_beat         r_out_data;

    logic                        pop, load_out;
    logic [bbrw_pkg::CNT_W:0]    trial [3];
    logic                        qbit [3];
    logic [bbrw_pkg::CH_W-1:0]   chan [3];

    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        load_out = 1'b0;
        case (r_state)
            bbrw_pkg::B_IDLE: begin
                if (i_queue.valid) begin
                    pop     = 1'b1;
                    n_state = bbrw_pkg::B_SCAN;
                end
            end
            bbrw_pkg::B_SCAN: begin
                if (r_col == r_job.c1 && r_row == r_job.r1) begin
                    n_state = bbrw_pkg::B_DRAIN;
                end
            end
            bbrw_pkg::B_DRAIN: n_state = bbrw_pkg::B_DIV;
            bbrw_pkg::B_DIV: begin
                if (r_step == bbrw_pkg::STEP_W'(bbrw_pkg::SUM_W - 1)) begin
                    n_state = bbrw_pkg::B_HOLD;
                end
            end
            bbrw_pkg::B_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = bbrw_pkg::B_IDLE;
                end
            end
            default: n_state = bbrw_pkg::B_IDLE;
        endcase
    end

    assign o_status.scan_busy = (r_state == bbrw_pkg::B_SCAN);
    assign o_status.pop       = pop;
    assign o_rd_en   = (r_state == bbrw_pkg::B_SCAN);
    assign o_rd_addr = bbrw_pkg::line_addr(r_slot, r_col);

    assign chan[0] = i_rd_data[23:16];
    assign chan[1] = i_rd_data[15:8];
    assign chan[2] = i_rd_data[7:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            trial[k] = {r_rem[k], r_sum[k][bbrw_pkg::SUM_W-1]};
            qbit[k]  = trial[k] >= (bbrw_pkg::CNT_W + 1)'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbrw_pkg::B_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == bbrw_pkg::B_SCAN);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job  <= i_queue.job;
            r_row  <= i_queue.job.r0;
            r_col  <= i_queue.job.c0;
            r_slot <= i_queue.job.slot0;
            r_cnt  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end
        if (r_state == bbrw_pkg::B_SCAN) begin
            if (r_col == r_job.c1) begin
                r_col  <= r_job.c0;
                r_row  <= r_row + bbrw_pkg::ROW_W'(1);
                r_slot <= (r_slot == bbrw_pkg::SLOT_W'(bbrw_pkg::RING - 1))
                        ? '0 : r_slot + bbrw_pkg::SLOT_W'(1);
            end else begin
                r_col <= r_col + bbrw_pkg::COL_W'(1);
            end
        end
        if (r_rd_vld) begin
            r_cnt <= r_cnt + bbrw_pkg::CNT_W'(1);
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= r_sum[k] + bbrw_pkg::SUM_W'(chan[k]);
            end
        end
        if (r_state == bbrw_pkg::B_DRAIN) begin
            r_step <= '0;
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= '0;
            end
        end
        if (r_state == bbrw_pkg::B_DIV) begin
            r_step <= r_step + bbrw_pkg::STEP_W'(1);
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= qbit[k]
                          ? bbrw_pkg::CNT_W'(trial[k] - (bbrw_pkg::CNT_W + 1)'(r_cnt))
                          : bbrw_pkg::CNT_W'(trial[k]);
                r_sum[k] <= {r_sum[k][bbrw_pkg::SUM_W-2:0], qbit[k]};
            end
        end
        if (load_out) begin
            r_out_data.blurred_color <= {r_sum[0][bbrw_pkg::CH_W-1:0],
                                         r_sum[1][bbrw_pkg::CH_W-1:0],
                                         r_sum[2][bbrw_pkg::CH_W-1:0]};
            r_out_data.out_column    <= bbrw_pkg::POS_W'(r_job.ec);
            r_out_data.out_row       <= bbrw_pkg::POS_W'(r_job.er);
            r_out_data.frame_done    <= r_job.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/box_blur_rgb_window.sv =====
// ----------------------------------------------------------------------------
// box_blur_rgb_window
// Streaming 7x7 box blur over raster-order RGB frames.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a command and a pixel. A pixel
// beat writes the next frame position into a seven-line store; a flush beat
// drains one pending output once the whole frame has arrived.
// Output channel: o_out_valid / i_out_stall carry the averaged pixel, its
// column and row, and frame_done on the last pixel of the frame.
// Frame size registers (index 0 width, index 1 height) are written on the
// i_cfg_we port and sampled at the first pixel of each frame.
// Pixel beats that produce no output are taken one per cycle while the
// input is not stalled. A beat that completes a window queues it; the
// back part then takes the window over, reads its N in-frame pixels (up
// to 49) from the line store one per cycle, drains the last read, runs
// a 14-step divider and loads the output register with the result.
// The input stalls from that beat until the window has been read, and
// longer while a queued window waits for the back part.
// While the output is stalled the result waits in the output register and
// further pixels are still taken until the next window has been queued.
// Reset clears the front counters, idles the back and restores width 320
// and height 200; the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_rgb_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  bbrw_pkg::t_in_beat             i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output bbrw_pkg::t_out_beat            o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [bbrw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bbrw_pkg::DIM_W-1:0]     i_cfg_data
);

    bbrw_pkg::t_queue               queue;
    bbrw_pkg::t_back_status         back_st;
    logic                           wr_en, rd_en;
    logic [bbrw_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
    logic [bbrw_pkg::PIX_W-1:0]     wr_data, rd_data;

    bbrw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_back     (back_st),
        .o_queue    (queue),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    bbrw_ram #(
        .WIDTH (bbrw_pkg::PIX_W),
        .DEPTH (bbrw_pkg::DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    bbrw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue     (queue),
        .o_status    (back_st),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hw/rtl/bbrw_checker.sv =====
// ----------------------------------------------------------------------------
// bbrw_checker
// Port-level assertions for the box blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_rgb_window_macros.svh"

module bbrw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input bbrw_pkg::t_in_beat             i_in_data,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input bbrw_pkg::t_out_beat            o_out_data,
    input logic                           i_out_stall,
    input logic                           i_cfg_we,
    input logic [bbrw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [bbrw_pkg::DIM_W-1:0]     i_cfg_data
);

    `BBRW_ASSERT_NEXT(a_rst_no_out, !i_rst_n, !o_out_valid, "output valid after reset")
    `BBRW_ASSERT_NEXT(a_rst_ready, !i_rst_n, !o_in_stall, "input stalled after reset")
    `BBRW_ASSERT_NEXT_RST(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "beat dropped")
    `BBRW_ASSERT_NEXT_RST(a_frame_gap, o_out_valid && !i_out_stall && o_out_data.frame_done, !o_out_valid, "beat right after frame end")

endmodule

bind box_blur_rgb_window bbrw_checker u_chk (.*);

// ===== test/blur_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blur_checker
// Watches the blur's channels, computes the expected blurred pixels and
// compares every output beat with the oldest pending prediction.
// ----------------------------------------------------------------------------
module blur_checker
    import bbrw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_beat             i_in_data,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  t_out_beat            i_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    logic [PIX_W-1:0] lines [RING][LINE_W];
    int               in_col, in_row, em_col, em_row;
    bit               all_in;
    logic [DIM_W-1:0] width_reg, height_reg;
    int               act_w, act_h;
    t_out_beat        blur_q[$];

    assign o_pending = blur_q.size();

    task automatic push_window();
        int        r0, r1, c0, c1, cnt;
        int        sr, sg, sb;
        logic [PIX_W-1:0] p;
        t_out_beat b;
        bit        last;
        r0 = (em_row > RADIUS) ? em_row - RADIUS : 0;
        r1 = (em_row + RADIUS < act_h) ? em_row + RADIUS : act_h - 1;
        c0 = (em_col > RADIUS) ? em_col - RADIUS : 0;
        c1 = (em_col + RADIUS < act_w) ? em_col + RADIUS : act_w - 1;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                p = lines[r % RING][c];
                sr += p[23:16];
                sg += p[15:8];
                sb += p[7:0];
                cnt++;
            end
        end
        b.blurred_color = {8'(sr / cnt), 8'(sg / cnt), 8'(sb / cnt)};
        b.out_column    = POS_W'(em_col);
        b.out_row       = POS_W'(em_row);
        last            = (em_row == act_h - 1) && (em_col == act_w - 1);
        b.frame_done    = last;
        blur_q.push_back(b);
        if (last) begin
            in_col = 0; in_row = 0; em_col = 0; em_row = 0; all_in = 0;
        end else begin
            em_col++;
            if (em_col >= act_w) begin
                em_col = 0;
                em_row++;
            end
        end
    endtask

    function automatic int bound(int v, int lo, int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    task automatic take_beat(t_in_beat d);
        int seen, done_pos;
        if (d.command == CMD_FLUSH) begin
            if (all_in) push_window();
            return;
        end
        if (all_in) return;
        if (in_row == 0 && in_col == 0) begin
            act_w = bound(int'(width_reg), RING, LINE_W);
            act_h = bound(int'(height_reg), RING, MAX_HEIGHT);
        end
        lines[in_row % RING][in_col] = d.pixel_color;
        in_col++;
        if (in_col >= act_w) begin
            in_col = 0;
            in_row++;
            if (in_row >= act_h) begin
                in_row = 0;
                all_in = 1;
            end
        end
        seen     = all_in ? act_w * act_h : in_row * act_w + in_col;
        done_pos = em_row * act_w + em_col;
        if (seen - done_pos > RADIUS * act_w + RADIUS) push_window();
    endtask

    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            in_col = 0; in_row = 0; em_col = 0; em_row = 0; all_in = 0;
            width_reg  = CFG_W_RST;
            height_reg = CFG_H_RST;
            act_w = 320; act_h = 200;
            blur_q.delete();
            o_fail_count <= 0;
            o_checked    <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked <= o_checked + 1;
                if (blur_q.size() == 0) begin
                    $display("%0t: unexpected beat color=%h col=%0d row=%0d done=%b", $time,
                             i_out_data.blurred_color, i_out_data.out_column,
                             i_out_data.out_row, i_out_data.frame_done);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = blur_q.pop_front();
                    if (e.blurred_color !== i_out_data.blurred_color
                        || e.out_column !== i_out_data.out_column
                        || e.out_row !== i_out_data.out_row
                        || e.frame_done !== i_out_data.frame_done) begin
                        $display("%0t: mismatch exp color=%h col=%0d row=%0d done=%b",
                                 $time, e.blurred_color, e.out_column, e.out_row,
                                 e.frame_done);
                        $display("%0t:          act color=%h col=%0d row=%0d done=%b",
                                 $time, i_out_data.blurred_color, i_out_data.out_column,
                                 i_out_data.out_row, i_out_data.frame_done);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_beat(i_in_data);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_idx == CFG_FRAME_HEIGHT) height_reg = i_cfg_data;
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Frame-level stimulus for the RGB box blur: directed and random frames,
// out-of-range sizes, stray flush and pixel beats, random idling on both
// channels and one long output hold-off. Checking is done by blur_checker.
// ----------------------------------------------------------------------------
module tb;
    import bbrw_pkg::*;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 in_valid = 0;
    t_in_beat             in_data = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_beat            out_data;
    logic                 out_stall = 0;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;
    int                   fail_count, pending, checked;

    int gap_max = 10;
    bit hold_now = 0;
    int beats_sent = 0;
    int frames_run = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    box_blur_rgb_window u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_data(out_data), .i_out_stall(out_stall),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    blur_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .i_in_stall(in_stall),
        .i_out_valid(out_valid), .i_out_data(out_data), .i_out_stall(out_stall),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // output side: random stall per beat, plus one long hold-off on request
    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_now) begin
                out_stall <= 1;
                repeat (3000) @(posedge i_clk);
                hold_now = 0;
                out_stall <= 0;
                @(posedge i_clk);
            end
            g = $urandom_range(0, gap_max);
            if (g > 0) begin
                out_stall <= 1;
                repeat (g) @(posedge i_clk);
                out_stall <= 0;
            end
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_beat(t_cmd cmd, logic [PIX_W-1:0] pix);
        int g;
        g = $urandom_range(0, gap_max);
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1;
        in_data  <= '{command: cmd, pixel_color: pix};
        do @(posedge i_clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DIM_W-1:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int mode);
        case (mode)
            0:       return 24'h000000;
            1:       return 24'hffffff;
            2:       return {3{8'($urandom_range(250, 255))}};
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // one frame: size, pixels with stray flushes, stray pixels, drain
    task automatic run_frame(int wv, int hv, bit extremes, bit noise);
        int aw, ah;
        aw = (wv < RING) ? RING : (wv > LINE_W) ? LINE_W : wv;
        ah = (hv < RING) ? RING : (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
        write_reg(CFG_FRAME_WIDTH, DIM_W'(wv));
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(hv));
        for (int i = 0; i < aw * ah; i++) begin
            if (noise && $urandom_range(0, 19) == 0)
                send_beat(CMD_FLUSH, PIX_W'($urandom));
            send_beat(CMD_PIXEL, extremes ? pick_pixel(i % 5) : PIX_W'($urandom));
        end
        if (noise) begin
            repeat ($urandom_range(0, 2)) send_beat(CMD_PIXEL, PIX_W'($urandom));
        end
        for (int i = 0; i < RADIUS * aw + RADIUS; i++)
            send_beat(CMD_FLUSH, PIX_W'($urandom));
        if (noise && $urandom_range(0, 1)) send_beat(CMD_FLUSH, PIX_W'($urandom));
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        frames_run++;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: smallest frame with extreme colors and stray beats
        run_frame(7, 7, 1, 1);
        // sizes below range, then a wider line with height below range
        gap_max = 0;
        run_frame(3, 0, 1, 0);
        gap_max = 1;
        run_frame(30, 6, 0, 0);

        // random frames; the first one runs under a long output hold-off
        hold_now = 1;
        gap_max  = 10;
        while (beats_sent < 700) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            run_frame($urandom_range(4, 22), $urandom_range(4, 13), 0, 1);
        end

        $display("frames run: %0d, input beats: %0d, output beats checked: %0d",
                 frames_run, beats_sent, checked);
        $display("covered clamped sizes, stray flush/pixel beats, idling and hold-off");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("FAILURE");
        $finish;
    end

endmodule
